// ===== rtl/streaming_local_alignment_column_max_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef STREAMING_LOCAL_ALIGNMENT_COLUMN_MAX_DEFINES_SVH
`define STREAMING_LOCAL_ALIGNMENT_COLUMN_MAX_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SLACM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SLACM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/slacm_pkg.sv =====
package slacm_pkg;

  localparam int QUERY_MAX_DEF = 64;
  localparam int SCORE_W       = 14;
  localparam int SYM_W         = 8;
  localparam int POS_W         = 6;
  localparam int QLEN_W        = 7;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CAND_W        = SCORE_W + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_REF   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH    = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_QLEN     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] query_position;
  } item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] peak_score;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] match;
    logic [CFG_W-1:0] mismatch;
    logic [CFG_W-1:0] gap;
  } score_cfg_t;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] above;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] best;
  } wave_t;

  typedef struct packed {
    logic             load;
    logic             clear;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
  } cell_ctl_t;

endpackage

// ===== rtl/slacm_if.sv =====
interface slacm_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/slacm_cell.sv =====
module slacm_cell #(
  parameter int IDX = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  slacm_pkg::cell_ctl_t                 ctl_i,
  input  slacm_pkg::score_cfg_t                cfg_i,
  input  logic [slacm_pkg::QLEN_W-1:0]         qlen_i,
  input  logic [slacm_pkg::SYM_W-1:0]          ref_sym_i,
  input  slacm_pkg::wave_t                     wave_i,
  output slacm_pkg::wave_t                     wave_o
);

  logic [slacm_pkg::SYM_W-1:0]   q_sym_q;
  logic [slacm_pkg::SCORE_W-1:0] prev_q;
  slacm_pkg::wave_t              wave_q;

  logic                          row_act;
  logic signed [slacm_pkg::CAND_W-1:0] up_s, left_s, diag_s, best_s;
  logic [slacm_pkg::SCORE_W-1:0] cell_v;
  logic [slacm_pkg::SCORE_W-1:0] best_v;

  always_comb begin
    row_act = wave_i.valid && (int'(qlen_i) > IDX);
    up_s    = $signed({2'b00, wave_i.above}) - $signed({8'd0, cfg_i.gap});
    left_s  = $signed({2'b00, prev_q}) - $signed({8'd0, cfg_i.gap});
    if (q_sym_q == ref_sym_i) begin
      diag_s = $signed({2'b00, wave_i.diag}) + $signed({8'd0, cfg_i.match});
    end else begin
      diag_s = $signed({2'b00, wave_i.diag}) - $signed({8'd0, cfg_i.mismatch});
    end
    best_s = '0;
    if (up_s > best_s) begin
      best_s = up_s;
    end
    if (left_s > best_s) begin
      best_s = left_s;
    end
    if (diag_s > best_s) begin
      best_s = diag_s;
    end
    if (best_s > $signed({2'b00, slacm_pkg::SCORE_MAX})) begin
      cell_v = slacm_pkg::SCORE_MAX;
    end else begin
      cell_v = best_s[slacm_pkg::SCORE_W-1:0];
    end
    best_v = (cell_v > wave_i.best) ? cell_v : wave_i.best;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && (int'(ctl_i.position) == IDX)) begin
      q_sym_q <= ctl_i.symbol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctl_i.clear) begin
      prev_q <= '0;
    end else if (adv_i && row_act) begin
      prev_q <= cell_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else if (adv_i) begin
      wave_q.valid <= wave_i.valid;
      wave_q.above <= row_act ? cell_v : wave_i.above;
      wave_q.diag  <= prev_q;
      wave_q.best  <= row_act ? best_v : wave_i.best;
    end
  end

  assign wave_o = wave_q;

endmodule

// ===== rtl/streaming_local_alignment_column_max.sv =====
// Local alignment scorer with a linear gap penalty, one table column per reference beat.
// Input channel in_if carries an action, a symbol and a query position. A load beat
// writes one query symbol into the cell of that position and a clear beat zeroes the kept
// column. A reference beat sends a wavefront down the row of QUERY_MAX cells, one cell
// per cycle unless the row holds, and its column maximum passes through start_q and the
// cell registers to the output register on out_if. in_if.ready stays low until the result
// enters the output register, so a new beat waits for the row to finish but is accepted
// while the result waits. If the receiver stalls with the output register full when a new
// result reaches the end of the row, the whole row holds until out_if.ready returns. The
// configuration port writes one register per cycle with cfg_we_i; the user must see that
// it is used only while the block is idle, which the block does not enforce. Reset clears
// the kept column, the control state and sets the score registers to one and the query
// length to zero; query symbols stay undefined until loaded.
module streaming_local_alignment_column_max #(
  parameter int QUERY_MAX = slacm_pkg::QUERY_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  slacm_if.sink                               in_if,
  slacm_if.source                             out_if,
  input  logic                                cfg_we_i,
  input  logic [slacm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [slacm_pkg::CFG_W-1:0]         cfg_data_i
);

  slacm_pkg::score_cfg_t            cfg_q;
  logic [slacm_pkg::QLEN_W-1:0]     qlen_q;
  logic [slacm_pkg::SYM_W-1:0]      ref_sym_q;
  logic                             busy_q;
  logic                             start_q;
  logic                             out_valid_q;
  logic [slacm_pkg::SCORE_W-1:0]    out_data_q;

  logic                             accept;
  logic                             ref_acc;
  logic                             adv;
  slacm_pkg::cell_ctl_t             ctl;
  slacm_pkg::wave_t                 wave [QUERY_MAX+1];
  slacm_pkg::wave_t                 last;

  assign in_if.ready = !busy_q;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    ctl.load     = 1'b0;
    ctl.clear    = 1'b0;
    ctl.symbol   = in_if.data.symbol;
    ctl.position = in_if.data.query_position;
    ref_acc      = 1'b0;
    unique case (in_if.data.action)
      slacm_pkg::ACT_LOAD:  ctl.load  = accept;
      slacm_pkg::ACT_REF:   ref_acc   = accept;
      slacm_pkg::ACT_CLEAR: ctl.clear = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match    <= 8'd1;
      cfg_q.mismatch <= 8'd1;
      cfg_q.gap      <= 8'd1;
      qlen_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        slacm_pkg::CFG_MATCH:    cfg_q.match    <= cfg_data_i;
        slacm_pkg::CFG_MISMATCH: cfg_q.mismatch <= cfg_data_i;
        slacm_pkg::CFG_GAP:      cfg_q.gap      <= cfg_data_i;
        slacm_pkg::CFG_QLEN:     qlen_q         <= cfg_data_i[slacm_pkg::QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ref_acc) begin
      ref_sym_q <= in_if.data.symbol;
    end
  end

  assign wave[0].valid = start_q;
  assign wave[0].above = '0;
  assign wave[0].diag  = '0;
  assign wave[0].best  = '0;

  for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
    slacm_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ctl_i     (ctl),
      .cfg_i     (cfg_q),
      .qlen_i    (qlen_q),
      .ref_sym_i (ref_sym_q),
      .wave_i    (wave[g]),
      .wave_o    (wave[g+1])
    );
  end

  assign last = wave[QUERY_MAX];
  assign adv  = !(last.valid && out_valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= ref_acc;
      if (ref_acc) begin
        busy_q <= 1'b1;
      end else if (last.valid && adv) begin
        busy_q <= 1'b0;
      end
      if (last.valid && adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid && adv) begin
      out_data_q <= last.best;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.data.peak_score = out_data_q;

endmodule

// ===== rtl/slacm_checker.sv =====
`include "streaming_local_alignment_column_max_defines.svh"

module slacm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [1:0]                    in_action_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [slacm_pkg::SCORE_W-1:0] out_data_i
);

  `SLACM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped while stalled")
  `SLACM_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_data_i), "stalled result changed")
  `SLACM_ASSERT(a_ref_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_action_i == 2'(slacm_pkg::ACT_REF)) |=> !in_ready_i, "input still ready after a reference beat")
  `SLACM_ASSERT(a_result_cause, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i), "result appeared without a reference beat in flight")
  `SLACM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind streaming_local_alignment_column_max slacm_checker u_slacm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_action_i (in_if.data.action),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data.peak_score)
);
